[design/ols_pkg.sv]
// ----------------------------------------------------------------------------
// ols_pkg: shared types and codes for the ordered list store
// Request modes, status codes, data type and per-cell control group.
// ----------------------------------------------------------------------------
package ols_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned ModeW        = 3;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned DefListDepth = 16;

  typedef logic signed [DataW-1:0] data_t;

  // request modes
  typedef enum logic [ModeW-1:0] {
    MODE_APPEND   = 3'd0,
    MODE_DEL_HEAD = 3'd1,
    MODE_DEL_TAIL = 3'd2,
    MODE_DEL_POS  = 3'd3,
    MODE_READ_POS = 3'd4
  } mode_t;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_NOPOS = 2'd3
  } status_t;

  // control group driven into each cell
  typedef struct packed {
    logic load;      // take the appended value
    logic shift;     // take the neighbor's value (delete closes the gap)
    logic read_sel;  // this cell is the one being read
  } cell_ctrl_t;

endpackage

[design/ordered_list_store.sv]
// ----------------------------------------------------------------------------
// ordered_list_store: bounded ordered list with positional delete
// Output: a result appears in the output register in the cycle after its
//   transaction is accepted.
// Throughput: one transaction per cycle when not stalled; all cells update in
//   parallel in the accepting cycle, the output register holds while stalled.
// Reset: clears the entry count and the output valid; entries are not cleared.
// ----------------------------------------------------------------------------
module ordered_list_store #(
  parameter  int unsigned LIST_DEPTH = ols_pkg::DefListDepth,
  localparam int unsigned CountW     = $clog2(LIST_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [ols_pkg::ModeW-1:0] mode,
  input  ols_pkg::data_t            value,
  input  logic [CountW-1:0]         position,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ols_pkg::StatusW-1:0] status,
  output logic [CountW-1:0]         length,
  output ols_pkg::data_t            read_value
);
  import ols_pkg::*;

  logic        accept;
  logic [CountW-1:0] count;
  logic [CountW-1:0] count_next;
  logic [CountW-1:0] del_idx;
  status_t     status_next;
  logic        do_append;
  logic        do_delete;
  logic        do_read;
  logic        is_empty;
  logic        is_full;
  logic        pos_bad;

  cell_ctrl_t  ctrl  [LIST_DEPTH];
  data_t       cell_value [LIST_DEPTH];
  data_t       read_chain [LIST_DEPTH+1];

  // handshake: take a transaction whenever the output register can move
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign is_empty = (count == '0);
  assign is_full  = (count == CountW'(LIST_DEPTH));
  assign pos_bad  = (position == '0) || (position > count);

  // request decode
  always_comb begin
    status_next = ST_DONE;
    count_next  = count;
    del_idx     = '0;
    do_append   = 1'b0;
    do_delete   = 1'b0;
    do_read     = 1'b0;
    unique case (mode)
      MODE_APPEND: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          do_append  = 1'b1;
          count_next = count + 1'b1;
        end
      end
      MODE_DEL_HEAD: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          do_delete  = 1'b1;
          count_next = count - 1'b1;
        end
      end
      MODE_DEL_TAIL: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      MODE_DEL_POS, MODE_READ_POS: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else if (pos_bad) begin
          status_next = ST_NOPOS;
        end else if (mode == MODE_DEL_POS) begin
          do_delete  = 1'b1;
          del_idx    = position - 1'b1;
          count_next = count - 1'b1;
        end else begin
          do_read = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // row of cells; the read chain runs from the tail toward the head
  assign read_chain[LIST_DEPTH] = '0;

  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    data_t nb_value;

    if (k == LIST_DEPTH - 1) begin : g_last
      assign nb_value = cell_value[k];
    end else begin : g_mid
      assign nb_value = cell_value[k+1];
    end

    // per-cell control from its own index
    assign ctrl[k].load     = accept & do_append & (count == CountW'(k));
    assign ctrl[k].shift    = accept & do_delete & (CountW'(k) >= del_idx);
    assign ctrl[k].read_sel = do_read & (position == CountW'(k + 1));

    ols_cell u_cell (
      .clk            (clk),
      .ctrl           (ctrl[k]),
      .new_value      (value),
      .neighbor_value (nb_value),
      .read_in        (read_chain[k+1]),
      .value          (cell_value[k]),
      .read_out       (read_chain[k])
    );
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      length     <= count_next;
      read_value <= read_chain[0];
    end
  end

endmodule

[design/ols_cell.sv]
// ----------------------------------------------------------------------------
// ols_cell: one entry of the ordered list
// Holds one value, loads an appended value or the neighbor's value on a
// delete, and merges its value into the read chain when selected.
// ----------------------------------------------------------------------------
module ols_cell (
  input  logic               clk,
  input  ols_pkg::cell_ctrl_t ctrl,
  input  ols_pkg::data_t      new_value,
  input  ols_pkg::data_t      neighbor_value,
  input  ols_pkg::data_t      read_in,
  output ols_pkg::data_t      value,
  output ols_pkg::data_t      read_out
);
  import ols_pkg::*;

  // entry register, no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value <= new_value;
    end else if (ctrl.shift) begin
      value <= neighbor_value;
    end
  end

  // read chain merge
  assign read_out = ctrl.read_sel ? (read_in | value) : read_in;

endmodule

[bench/ordered_list_store_tb.sv]
// ----------------------------------------------------------------------------
// ordered_list_store_tb: self-checking bench for the ordered list store
// Drives list requests through the valid/stall input channel, predicts each
// status, length and read value with a local list model, and compares every
// result transaction in order. Directed cases cover empty, full, head, tail
// and out-of-range positions; a long random mix follows with stalls on both
// sides.
// ----------------------------------------------------------------------------
module ordered_list_store_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ols_pkg::*;

  localparam int unsigned Depth  = DefListDepth;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int          IdleLimit = 2000;
  localparam int          RandomItems = 1450;

  // mode codes the block treats as no operation
  localparam logic [ModeW-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [ModeW-1:0] MODE_SPARE_HI = 3'd7;

  typedef struct {
    status_t           outcome;
    logic [CountW-1:0] len;
    data_t             rd;
  } list_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [ModeW-1:0]  mode;
  data_t             value;
  logic [CountW-1:0] position;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [StatusW-1:0] status;
  logic [CountW-1:0] length;
  data_t             read_value;

  // list model and expected results
  data_t        held_entries [Depth];
  int unsigned  held_count;
  list_result_t pending_results [$];

  // bookkeeping
  logic quiet = 1'b0;
  int   fail_count = 0;
  int   checked_count = 0;
  int   counted_items = 0;
  int   idle_cycles = 0;
  int   mode_tally [8];
  int   outcome_tally [4];

  ordered_list_store dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .value      (value),
    .position   (position),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .length     (length),
    .read_value (read_value)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // one line per mismatch, count all of them
  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    fail_count++;
    $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what, got,
             want);
  endtask

  // remove one entry, later entries move toward the head
  function automatic void close_gap(input int unsigned idx);
    for (int unsigned k = idx; k + 1 < held_count; k++)
      held_entries[k] = held_entries[k + 1];
    held_count--;
  endfunction

  // list behavior for one accepted request
  task automatic apply_request(input logic [ModeW-1:0] op, input data_t val,
                               input logic [CountW-1:0] pos, output list_result_t res);
    res.outcome = ST_DONE;
    res.rd      = '0;
    case (op)
      MODE_APPEND: begin
        if (held_count >= Depth) res.outcome = ST_FULL;
        else begin
          held_entries[held_count] = val;
          held_count++;
        end
      end
      MODE_DEL_HEAD: begin
        if (held_count == 0) res.outcome = ST_EMPTY;
        else close_gap(0);
      end
      MODE_DEL_TAIL: begin
        if (held_count == 0) res.outcome = ST_EMPTY;
        else held_count--;
      end
      MODE_DEL_POS, MODE_READ_POS: begin
        if (held_count == 0) res.outcome = ST_EMPTY;
        else if (pos == 0 || pos > held_count) res.outcome = ST_NOPOS;
        else if (op == MODE_DEL_POS) close_gap(pos - 1);
        else res.rd = held_entries[pos - 1];
      end
      default: ;
    endcase
    res.len = CountW'(held_count);
  endtask

  // drive one request, predict it once it is accepted
  task automatic send_request(input logic [ModeW-1:0] op, input data_t val,
                              input logic [CountW-1:0] pos);
    list_result_t res;
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op;
    value    <= val;
    position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_request(op, val, pos, res);
    pending_results.push_back(res);
    mode_tally[op]++;
    outcome_tally[res.outcome]++;
    if (op <= MODE_READ_POS) counted_items++;
    @(negedge clk);
  endtask

  // hold the sender off until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // tail delete on a single entry empties the list
  task automatic test_single_entry();
    send_request(MODE_APPEND, 32'sh0000_1234, '0);
    send_request(MODE_DEL_TAIL, '0, '0);
  endtask

  // deletes and reads on an empty list
  task automatic test_empty_list();
    send_request(MODE_DEL_HEAD, '0, 5'd1);
    send_request(MODE_DEL_POS, '0, 5'd1);
    send_request(MODE_READ_POS, '1, 5'd1);
  endtask

  // fill with extreme values, then one refused append
  task automatic test_fill_to_full();
    send_request(MODE_APPEND, 32'sh7fff_ffff, '0);
    send_request(MODE_APPEND, 32'sh8000_0000, '0);
    send_request(MODE_APPEND, '0, '0);
    send_request(MODE_APPEND, '1, '1);
    for (int k = 4; k < Depth; k++)
      send_request(MODE_APPEND, data_t'($urandom), CountW'($urandom));
    send_request(MODE_APPEND, 32'sh5a5a_5a5a, '0);
  endtask

  // last position, position zero, past the end, head delete, spare mode
  task automatic test_positions();
    send_request(MODE_READ_POS, '0, CountW'(Depth));
    send_request(MODE_READ_POS, '0, '0);
    send_request(MODE_DEL_POS, '0, CountW'(Depth + 1));
    send_request(MODE_DEL_POS, '0, 5'd1);
    send_request(MODE_SPARE_HI, '1, '1);
  endtask

  // bursts leaning toward filling, draining or neither
  task automatic test_random_mix(input int target);
    int               burst_len;
    int               append_pct;
    int               pick;
    int               bursts;
    logic [ModeW-1:0] op;
    data_t            val;
    logic [CountW-1:0] pos;
    bursts = 0;
    while (counted_items < target) begin
      burst_len = $urandom_range(60, 20);
      case ($urandom_range(2))
        0:       append_pct = 75;
        1:       append_pct = 20;
        default: append_pct = 45;
      endcase
      quiet = (bursts >= 10 && bursts < 18);
      if (bursts % 9 == 8) drain_results();
      repeat (burst_len) begin
        pick = $urandom_range(99);
        if (pick < 3)
          op = ModeW'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
        else if (pick < 3 + append_pct)
          op = MODE_APPEND;
        else begin
          case ($urandom_range(5))
            0:       op = MODE_DEL_HEAD;
            1:       op = MODE_DEL_TAIL;
            2, 3:    op = MODE_DEL_POS;
            default: op = MODE_READ_POS;
          endcase
        end
        case ($urandom_range(19))
          0:       val = 32'sh7fff_ffff;
          1:       val = 32'sh8000_0000;
          2:       val = '0;
          3:       val = '1;
          default: val = data_t'($urandom);
        endcase
        // mostly a valid position, sometimes zero or past the end
        if (held_count != 0 && $urandom_range(99) < 80)
          pos = CountW'($urandom_range(held_count, 1));
        else if ($urandom_range(3) == 0)
          pos = '0;
        else
          pos = CountW'($urandom_range((1 << CountW) - 1, held_count + 1));
        send_request(op, val, pos);
      end
      bursts++;
    end
    quiet = 1'b0;
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 15);
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing pending", 32'(status), '0);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (status !== want.outcome)
          note_mismatch("status", 32'(status), 32'(want.outcome));
        if (length !== want.len)
          note_mismatch("length", 32'(length), 32'(want.len));
        if (read_value !== want.rd) note_mismatch("read_value", read_value, want.rd);
      end
    end
  end

  // cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("timeout: no transaction for %0d cycles", IdleLimit);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int spare_total;
    rst        = 1'b1;
    in_valid   = 1'b0;
    mode       = MODE_APPEND;
    value      = '0;
    position   = '0;
    held_count = 0;
    foreach (mode_tally[k]) mode_tally[k] = 0;
    foreach (outcome_tally[k]) outcome_tally[k] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_single_entry();
    test_empty_list();
    test_fill_to_full();
    test_positions();
    drain_results();
    test_random_mix(counted_items + RandomItems);

    drain_results();
    repeat (4) @(posedge clk);
    spare_total = 0;
    for (int k = MODE_SPARE_LO; k <= MODE_SPARE_HI; k++)
      spare_total += mode_tally[k];
    $display("covered %0d requests: %0d append, %0d end delete, %0d position delete,",
             mode_tally.sum(), mode_tally[MODE_APPEND],
             mode_tally[MODE_DEL_HEAD] + mode_tally[MODE_DEL_TAIL],
             mode_tally[MODE_DEL_POS]);
    $display("  %0d read, %0d spare mode; outcomes: %0d done, %0d empty, %0d full,",
             mode_tally[MODE_READ_POS], spare_total,
             outcome_tally[ST_DONE], outcome_tally[ST_EMPTY], outcome_tally[ST_FULL]);
    $display("  %0d not found; %0d results checked",
             outcome_tally[ST_NOPOS], checked_count);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[ordered_list_store.f]
design/ols_pkg.sv
design/ols_cell.sv
design/ordered_list_store.sv
bench/ordered_list_store_tb.sv
